>>> sv/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// types shared by the face flux divergence controller and datapath
// ----------------------------------------------------------------------------
package ffd_pkg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_OUT  = 5'b01000,
        S_WAIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic has_result;
    } t_status;

endpackage

>>> sv/ffd_if.sv
// ----------------------------------------------------------------------------
// ffd_in_if / ffd_out_if
// valid/ready channels carrying one face and one cell result
// ----------------------------------------------------------------------------
interface ffd_in_if #(parameter int DW = 32);
    logic          valid;
    logic          ready;
    logic [DW-1:0] flux;
    logic [DW-1:0] speed_minus;
    logic [DW-1:0] speed_plus;
    logic [DW-1:0] vel_minus;
    logic [DW-1:0] vel_plus;
    logic [DW-1:0] g_minus;
    logic [DW-1:0] g_plus;
    logic [DW-1:0] p_minus;
    logic [DW-1:0] p_plus;
    logic          row_end;
    modport source (output valid, flux, speed_minus, speed_plus, vel_minus, vel_plus,
                    g_minus, g_plus, p_minus, p_plus, row_end, input ready);
    modport sink (input valid, flux, speed_minus, speed_plus, vel_minus, vel_plus,
                  g_minus, g_plus, p_minus, p_plus, row_end, output ready);
endinterface

interface ffd_out_if #(parameter int DW = 32);
    logic          valid;
    logic          ready;
    logic [DW-1:0] flux_diff;
    logic [DW-1:0] divu_term;
    logic [DW-1:0] sum_g;
    logic [DW-1:0] sum_p;
    logic          cell_last;
    logic          div_fault;
    modport source (output valid, flux_diff, divu_term, sum_g, sum_p, cell_last,
                    div_fault, input ready);
    modport sink (input valid, flux_diff, divu_term, sum_g, sum_p, cell_last,
                  div_fault, output ready);
endinterface

>>> sv/ffd_ctrl.sv
// ----------------------------------------------------------------------------
// ffd_ctrl
// sequencer: accept, multiply, divide, deliver
// ----------------------------------------------------------------------------
module ffd_ctrl import ffd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.finish = 1'b1;
                n_state = i_status.has_result ? S_WAIT : S_IDLE;
            end
            S_WAIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> sv/ffd_dp.sv
// ----------------------------------------------------------------------------
// ffd_dp
// datapath: serial multiplier, restoring divider, saturating adders, face state
// ----------------------------------------------------------------------------
module ffd_dp import ffd_pkg::*; #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    input  logic [DW-1:0] i_flux,
    input  logic [DW-1:0] i_am,
    input  logic [DW-1:0] i_ap,
    input  logic [DW-1:0] i_um,
    input  logic [DW-1:0] i_up,
    input  logic [DW-1:0] i_gm,
    input  logic [DW-1:0] i_gp,
    input  logic [DW-1:0] i_pm,
    input  logic [DW-1:0] i_pp,
    input  logic          i_last,
    output logic [DW-1:0] o_flux_diff,
    output logic [DW-1:0] o_divu,
    output logic [DW-1:0] o_sum_g,
    output logic [DW-1:0] o_sum_p,
    output logic          o_cell_last,
    output logic          o_fault
);
    localparam int PW = 2 * DW + 1;
    localparam int NW = PW;
    localparam int MC = $clog2(DW + 1);
    localparam int DC = $clog2(NW + 1);

    logic [DW-1:0] r_flux, r_gm, r_gp, r_pp, r_pm;
    logic          r_last;
    logic [DW:0]   r_den;
    logic          r_den_neg;
    logic [DW-1:0] r_ma, r_mb, r_mc, r_md;
    logic          r_neg1, r_neg2;
    logic [2*DW-1:0] r_acc1, r_acc2;
    logic [MC-1:0] r_mcnt;
    logic [NW-1:0] r_num;
    logic [DW+1:0] r_rem;
    logic          r_qneg;
    logic [DC-1:0] r_dcnt;
    logic          r_fault;

    logic          r_have_prev, r_prev_fault;
    logic [DW-1:0] r_prev_flux, r_prev_mixed, r_prev_gp, r_prev_pp;

    function automatic logic [DW-1:0] f_abs(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DW-1:0] f_sat(input logic [DW:0] v);
        if (v[DW] != v[DW-1]) return v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        return v[DW-1:0];
    endfunction

    logic [DW:0] den_w;
    assign den_w = {i_ap[DW-1], i_ap} - {i_am[DW-1], i_am};

    // signed products assembled and difference taken
    logic [PW-1:0] s1, s2, num_w, num_mag;
    assign s1 = r_neg1 ? ~{1'b0, r_acc1} + 1'b1 : {1'b0, r_acc1};
    assign s2 = r_neg2 ? ~{1'b0, r_acc2} + 1'b1 : {1'b0, r_acc2};
    assign num_w = s1 - s2;
    assign num_mag = num_w[PW-1] ? ~num_w + 1'b1 : num_w;

    logic [DW+1:0] rem_sh, rem_sub;
    assign rem_sh = {r_rem[DW:0], r_num[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // quotient grows in r_num low bits as dividend shifts out
    logic [NW-1:0] q_mag;
    logic [NW:0]   q_s;
    logic [DW-1:0] mixed;
    logic          q_ovf;
    assign q_mag = r_num;
    assign q_s = r_qneg ? ~{1'b0, q_mag} + 1'b1 : {1'b0, q_mag};
    assign q_ovf = r_qneg ? (q_mag > {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}} + 1'b1)
                          : (q_mag > {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}});
    assign mixed = r_fault ? '0 :
                   q_ovf ? (r_qneg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                         : q_s[DW-1:0];

    assign o_status.mul_done = (r_mcnt == MC'(DW));
    assign o_status.div_done = r_fault || (r_dcnt == DC'(NW - 1));
    assign o_status.has_result = r_have_prev;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_flux <= i_flux;
            r_gm <= i_gm;
            r_gp <= i_gp;
            r_pm <= i_pm;
            r_pp <= i_pp;
            r_last <= i_last;
            r_den <= den_w[DW] ? ~den_w + 1'b1 : den_w;
            r_den_neg <= den_w[DW];
            r_fault <= (den_w == '0);
            r_ma <= f_abs(i_ap);
            r_mb <= f_abs(i_um);
            r_mc <= f_abs(i_am);
            r_md <= f_abs(i_up);
            r_neg1 <= i_ap[DW-1] ^ i_um[DW-1];
            r_neg2 <= i_am[DW-1] ^ i_up[DW-1];
            r_acc1 <= '0;
            r_acc2 <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.mul_step) begin
            r_acc1 <= (r_acc1 << 1) + (r_mb[DW-1] ? {{DW{1'b0}}, r_ma} : '0);
            r_acc2 <= (r_acc2 << 1) + (r_md[DW-1] ? {{DW{1'b0}}, r_mc} : '0);
            r_mb <= r_mb << 1;
            r_md <= r_md << 1;
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.div_start) begin
            r_num <= num_mag;
            r_rem <= '0;
            r_qneg <= num_w[PW-1] ^ r_den_neg;
            r_dcnt <= '0;
        end else if (i_cmd.div_step && !r_fault) begin
            if (!rem_sub[DW+1]) begin
                r_rem <= rem_sub;
                r_num <= {r_num[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_num <= {r_num[NW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.finish) begin
            o_flux_diff <= f_sat({r_flux[DW-1], r_flux} - {r_prev_flux[DW-1], r_prev_flux});
            o_divu <= f_sat({mixed[DW-1], mixed} - {r_prev_mixed[DW-1], r_prev_mixed});
            o_sum_g <= f_sat({r_gm[DW-1], r_gm} + {r_prev_gp[DW-1], r_prev_gp});
            o_sum_p <= f_sat({r_pm[DW-1], r_pm} + {r_prev_pp[DW-1], r_prev_pp});
            o_cell_last <= r_last;
            o_fault <= r_fault | r_prev_fault;
        end
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_fault <= 1'b0;
            r_prev_flux <= '0;
            r_prev_mixed <= '0;
            r_prev_gp <= '0;
            r_prev_pp <= '0;
        end else if (i_cmd.finish) begin
            r_have_prev <= !r_last;
            r_prev_fault <= r_last ? 1'b0 : r_fault;
            r_prev_flux <= r_last ? '0 : r_flux;
            r_prev_mixed <= r_last ? '0 : mixed;
            r_prev_gp <= r_last ? '0 : r_gp;
            r_prev_pp <= r_last ? '0 : r_pp;
        end
    end
endmodule

>>> sv/face_flux_divergence_row.sv
// ----------------------------------------------------------------------------
// face_flux_divergence_row
// finite-volume flux divergence along a row of faces, saturating fixed point
// ----------------------------------------------------------------------------
// usage
//   s_in carries one face per transfer; the first face of a row gives no
//   result, every later face gives one cell result on m_out.  a face with
//   row_end closes the row and the next face starts a new one.
//   per face: a shift-add multiply, a restoring division for the mixed term
//   (cut short when the speeds are equal), then the result is formed; m_out
//   valid follows, and the block returns to idle after the result transfer.
//   one face is in flight at a time; s_in ready is low while it is.
//   reset clears the held face, so the first face after reset starts a row.
//   a stalled receiver holds the result in the output register and the
//   block takes no new face until the result transfer completes.
// ----------------------------------------------------------------------------
module face_flux_divergence_row import ffd_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ffd_in_if.sink    s_in,
    ffd_out_if.source m_out
);
    t_cmd    cmd;
    t_status status;

    ffd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (s_in.ready),
        .o_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ffd_dp #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_flux      (s_in.flux),
        .i_am        (s_in.speed_minus),
        .i_ap        (s_in.speed_plus),
        .i_um        (s_in.vel_minus),
        .i_up        (s_in.vel_plus),
        .i_gm        (s_in.g_minus),
        .i_gp        (s_in.g_plus),
        .i_pm        (s_in.p_minus),
        .i_pp        (s_in.p_plus),
        .i_last      (s_in.row_end),
        .o_flux_diff (m_out.flux_diff),
        .o_divu      (m_out.divu_term),
        .o_sum_g     (m_out.sum_g),
        .o_sum_p     (m_out.sum_p),
        .o_cell_last (m_out.cell_last),
        .o_fault     (m_out.div_fault)
    );
endmodule

>>> verif/tb_face_flux_divergence_row.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_face_flux_divergence_row
// streams faces in rows, predicts each cell result in saturating fixed point
// and compares every result transfer field by field, with and without random idling
// ----------------------------------------------------------------------------
module tb_face_flux_divergence_row;
    import ffd_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int N_RANDOM = 1900;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef logic signed [DW-1:0] t_word;

    typedef struct {
        t_word flux, am, ap, um, up, gm, gp, pm, pp;
        logic  last;
    } t_face;

    typedef struct packed {
        t_word flux_diff, divu_term, sum_g, sum_p;
        logic  cell_last, div_fault;
    } t_cell;

    // directed row: face, whether a typed-in result applies, that result
    typedef struct {
        t_face f;
        logic  fixed;
        t_cell r;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    ffd_in_if  #(.DW(DW)) s_in();
    ffd_out_if #(.DW(DW)) m_out();

    face_flux_divergence_row #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in.sink), .m_out(m_out.source)
    );

    // predictor state
    logic  held;
    t_word held_flux, held_mixed, held_gp, held_pp;
    logic  held_fault;

    t_cell cells_due[$];
    t_cell fixed_due[$];
    logic  fixed_flag[$];
    int    errors;
    int    n_bad;
    int    snd_idle, rcv_idle;
    longint cycles;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    function automatic t_word sat_word(input logic signed [127:0] v);
        if (v > WMAX) return t_word'(WMAX);
        if (v < WMIN) return t_word'(WMIN);
        return t_word'(v);
    endfunction

    function automatic t_word face_mixed(input t_face f, output logic flt);
        logic signed [127:0] num, den;
        den = 128'(f.ap) - 128'(f.am);
        if (den == 0) begin
            flt = 1'b1;
            return '0;
        end
        flt = 1'b0;
        num = 128'(f.ap) * 128'(f.um) - 128'(f.am) * 128'(f.up);
        return sat_word(num / den);
    endfunction

    function automatic void predict_cell(input t_face f, input logic fixed, input t_cell r);
        t_word m;
        logic  flt;
        t_cell c;
        m = face_mixed(f, flt);
        if (held) begin
            c.flux_diff = sat_word(128'(f.flux) - 128'(held_flux));
            c.divu_term = sat_word(128'(m) - 128'(held_mixed));
            c.sum_g     = sat_word(128'(f.gm) + 128'(held_gp));
            c.sum_p     = sat_word(128'(f.pm) + 128'(held_pp));
            c.cell_last = f.last;
            c.div_fault = flt | held_fault;
            cells_due.push_back(c);
            fixed_due.push_back(r);
            fixed_flag.push_back(fixed);
        end
        if (f.last) begin
            held = 0; held_flux = 0; held_mixed = 0; held_fault = 0;
            held_gp = 0; held_pp = 0;
        end else begin
            held = 1; held_flux = f.flux; held_mixed = m; held_fault = flt;
            held_gp = f.gp; held_pp = f.pp;
        end
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return t_word'(WMAX);
            1: return t_word'(WMIN);
            2: return t_word'($urandom_range(0, 8)) - 4;
            3: return t_word'(int'($urandom_range(0, 32'h3ffff)) - 32'h20000);
            default: return t_word'($urandom());
        endcase
    endfunction

    function automatic t_face rand_face(input logic last);
        t_face f;
        f.flux = rand_word(); f.am = rand_word(); f.ap = rand_word();
        f.um = rand_word(); f.up = rand_word(); f.gm = rand_word();
        f.gp = rand_word(); f.pm = rand_word(); f.pp = rand_word();
        if ($urandom_range(0, 7) == 0) f.ap = f.am;
        f.last = last;
        return f;
    endfunction

    function automatic t_face mk(input t_word fl, am, ap, um, up, gm, gp, pm, pp,
                                 input logic last);
        t_face f;
        f.flux = fl; f.am = am; f.ap = ap; f.um = um; f.up = up;
        f.gm = gm; f.gp = gp; f.pm = pm; f.pp = pp; f.last = last;
        return f;
    endfunction

    function automatic t_cell mc(input t_word a, b, c, d, input logic l, flt);
        t_cell r;
        r.flux_diff = a; r.divu_term = b; r.sum_g = c; r.sum_p = d;
        r.cell_last = l; r.div_fault = flt;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // result checker and receiver idling
    initial begin
        t_cell e, a, fx;
        logic  use_fx;
        m_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_out.valid && m_out.ready) begin
                a = mc(m_out.flux_diff, m_out.divu_term, m_out.sum_g, m_out.sum_p,
                       m_out.cell_last, m_out.div_fault);
                if (cells_due.size() == 0) begin
                    errors++;
                    if (n_bad++ < 10) $display("unexpected result transfer");
                end else begin
                    e = cells_due.pop_front();
                    fx = fixed_due.pop_front();
                    use_fx = fixed_flag.pop_front();
                    if (use_fx && fx != e) e = fx;
                    if (a != e) begin
                        errors++;
                        if (n_bad++ < 10)
                            $display("mismatch exp %h %h %h %h %b %b got %h %h %h %h %b %b",
                                     e.flux_diff, e.divu_term, e.sum_g, e.sum_p,
                                     e.cell_last, e.div_fault, a.flux_diff, a.divu_term,
                                     a.sum_g, a.sum_p, a.cell_last, a.div_fault);
                    end
                end
            end
            m_out.ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    task automatic send_face(input t_face f, input logic fixed, input t_cell r);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.flux <= f.flux; s_in.speed_minus <= f.am; s_in.speed_plus <= f.ap;
        s_in.vel_minus <= f.um; s_in.vel_plus <= f.up; s_in.g_minus <= f.gm;
        s_in.g_plus <= f.gp; s_in.p_minus <= f.pm; s_in.p_plus <= f.pp;
        s_in.row_end <= f.last;
        do @(posedge i_clk); while (!s_in.ready);
        predict_cell(f, fixed, r);
    endtask

    task automatic drain();
        s_in.valid <= 1'b0;
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    t_row dir_rows[$];
    t_cell none;

    initial begin
        int i, k, len;
        errors = 0; n_bad = 0;
        snd_idle = 33; rcv_idle = 46;
        held = 0; held_flux = 0; held_mixed = 0; held_fault = 0;
        held_gp = 0; held_pp = 0;
        none = mc(0, 0, 0, 0, 0, 0);
        i_rst_n <= 1'b0;
        s_in.valid <= 1'b0;
        s_in.flux <= '0; s_in.speed_minus <= '0; s_in.speed_plus <= '0;
        s_in.vel_minus <= '0; s_in.vel_plus <= '0; s_in.g_minus <= '0;
        s_in.g_plus <= '0; s_in.p_minus <= '0; s_in.p_plus <= '0;
        s_in.row_end <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone row-end face, then zero faces with equal speeds
        dir_rows.push_back('{mk(5, 1, 1, 0, 0, 0, 0, 0, 0, 1), 0, none});
        dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mc(0, 0, 0, 0, 0, 1)});
        // max flux minus min flux saturates high, sums saturate
        dir_rows.push_back('{mk(t_word'(WMIN), 0, 65536, 0, 0, 0, t_word'(WMAX),
                                0, t_word'(WMIN), 0), 0, none});
        dir_rows.push_back('{mk(t_word'(WMAX), 0, 65536, 0, 0, t_word'(WMAX), 0,
                                t_word'(WMIN), 0, 1), 1,
                             mc(t_word'(WMAX), 0, t_word'(WMAX), t_word'(WMIN), 1, 0)});
        // extremes of speeds and velocities through the divider
        dir_rows.push_back('{mk(t_word'(WMAX), t_word'(WMIN), t_word'(WMAX), t_word'(WMAX),
                                t_word'(WMIN), t_word'(WMIN), t_word'(WMIN),
                                t_word'(WMAX), t_word'(WMAX), 0), 0, none});
        dir_rows.push_back('{mk(t_word'(WMIN), t_word'(WMAX), t_word'(WMIN), t_word'(WMIN),
                                t_word'(WMAX), t_word'(WMAX), 1, 1, 1, 0), 0, none});
        dir_rows.push_back('{mk(-1, 1, 2, 3, 4, -5, 6, -7, 8, 0), 0, none});
        dir_rows.push_back('{mk(-1, 65536, 65536, 3, 4, -5, 6, -7, 8, 0), 0, none});
        dir_rows.push_back('{mk(t_word'(WMAX), -65536, 65536, t_word'(WMAX), t_word'(WMAX),
                                0, 0, 0, 0, 1), 0, none});
        foreach (dir_rows[j]) send_face(dir_rows[j].f, dir_rows[j].fixed, dir_rows[j].r);

        for (k = 0; k < 3; k++) begin
            if (k == 1) begin snd_idle = 46; rcv_idle = 33; end
            if (k == 2) begin snd_idle = 0; rcv_idle = 0; end
            i = 0;
            while (i < N_RANDOM / 3) begin
                len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
                for (int j = 0; j < len; j++) begin
                    send_face(rand_face(j == len - 1 || $urandom_range(0, 30) == 0),
                              0, none);
                    i++;
                end
            end
            drain();
        end

        drain();
        if (errors == 0 && cells_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
